// ===== hw/rtl/rspd_pkg.sv =====
// shared types, codes and constants of the request slot pool dispatcher
`default_nettype none
package rspd_pkg;

  localparam int SLOTS          = 64;
  localparam int SIZE_MAX_BYTES = 4096;
  localparam int SLOT_AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W         = 7;
  localparam int LEN_W          = 13;
  localparam int COUNT_W        = 7;
  localparam int CFG_IW         = 1;

  localparam logic [SLOT_W-1:0] NIL = 7'd127;

  localparam logic [2:0] OP_ALLOC_READ  = 3'd0;
  localparam logic [2:0] OP_ALLOC_WRITE = 3'd1;
  localparam logic [2:0] OP_FREE        = 3'd2;
  localparam logic [2:0] OP_QUERY_STATE = 3'd3;
  localparam logic [2:0] OP_DISPATCH    = 3'd4;
  localparam logic [2:0] OP_COMPLETE    = 3'd5;
  localparam logic [2:0] OP_QUERY_SIZE  = 3'd6;

  localparam logic [2:0] STS_OK           = 3'd0;
  localparam logic [2:0] STS_TOO_LONG     = 3'd1;
  localparam logic [2:0] STS_OUT_OF_SLOTS = 3'd2;
  localparam logic [2:0] STS_INVALID_SLOT = 3'd3;
  localparam logic [2:0] STS_NOTHING      = 3'd4;
  localparam logic [2:0] STS_NO_CURRENT   = 3'd5;

  localparam logic [2:0] SLOT_VACANT   = 3'd0;
  localparam logic [2:0] SLOT_WAITING  = 3'd1;
  localparam logic [2:0] SLOT_PROGRESS = 3'd2;
  localparam logic [2:0] SLOT_DONE     = 3'd3;
  localparam logic [2:0] SLOT_ERROR    = 3'd4;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_KEY_LIMIT  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_DATA_LIMIT = 1'd1;

  typedef struct packed {
    logic [2:0]       op;
    logic [6:0]       slot_index;
    logic [LEN_W-1:0] key_length;
    logic [LEN_W-1:0] data_length;
    logic             transfer_failed;
    logic [LEN_W-1:0] transfer_size;
  } rspd_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         slot_out;
    logic [2:0]         slot_state;
    logic [1:0]         command;
    logic [LEN_W-1:0]   slot_size;
    logic [COUNT_W-1:0] free_count;
  } rspd_rsp_t;

  typedef struct packed {
    logic [2:0]       state;
    logic [1:0]       command;
    logic [LEN_W-1:0] size;
  } rspd_info_t;

  typedef struct packed {
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] prv;
  } rspd_link_t;

  typedef struct packed {
    logic               info_we;
    logic [SLOT_AW-1:0] info_waddr;
    rspd_info_t         info_wdata;
    logic [SLOT_AW-1:0] info_raddr;
    logic               link_we;
    logic [SLOT_AW-1:0] link_waddr;
    rspd_link_t         link_wdata;
    logic [SLOT_AW-1:0] link_raddr;
  } rspd_mem_cmd_t;

  function automatic rspd_link_t link_reset(logic [SLOT_AW-1:0] a);
    rspd_link_t l;
    l.nxt = (32'(a) + 1 < SLOTS) ? SLOT_W'(32'(a) + 1) : NIL;
    l.prv = (a != '0) ? SLOT_W'(32'(a) - 1) : NIL;
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rspd_ram.sv =====
// generic single write, single registered read ram
`default_nettype none
module rspd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rspd_store.sv =====
// slot info and link memories with per-entry written flags for reset values
`default_nettype none
module rspd_store (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rspd_pkg::rspd_mem_cmd_t cmd,
  output rspd_pkg::rspd_info_t         info_rd,
  output rspd_pkg::rspd_link_t         link_rd
);
  import rspd_pkg::*;

  logic [SLOTS-1:0]   info_vld;
  logic [SLOTS-1:0]   link_vld;
  logic               info_hit;
  logic               link_hit;
  logic [SLOT_AW-1:0] link_raddr_q;
  rspd_info_t         info_ram;
  rspd_link_t         link_ram;

  rspd_ram #(.WIDTH($bits(rspd_info_t)), .DEPTH(SLOTS)) u_info_ram (
    .clk   (clk),
    .we    (cmd.info_we),
    .waddr (cmd.info_waddr),
    .wdata (cmd.info_wdata),
    .raddr (cmd.info_raddr),
    .rdata (info_ram)
  );

  rspd_ram #(.WIDTH($bits(rspd_link_t)), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (cmd.link_we),
    .waddr (cmd.link_waddr),
    .wdata (cmd.link_wdata),
    .raddr (cmd.link_raddr),
    .rdata (link_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      info_vld <= '0;
      link_vld <= '0;
      info_hit <= 1'b0;
      link_hit <= 1'b0;
    end else begin
      info_hit <= info_vld[cmd.info_raddr];
      link_hit <= link_vld[cmd.link_raddr];
      if (cmd.info_we) begin
        info_vld[cmd.info_waddr] <= 1'b1;
      end
      if (cmd.link_we) begin
        link_vld[cmd.link_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    link_raddr_q <= cmd.link_raddr;
  end

  // vacant, no command, zero size
  assign info_rd = info_hit ? info_ram : '0;
  assign link_rd = link_hit ? link_ram : link_reset(link_raddr_q);

endmodule
`default_nettype wire

// ===== hw/rtl/request_slot_pool_dispatcher.sv =====
// request slot pool dispatcher top level: operation sequencer and output register
// from accept to result in the output register: refused operations and unknown op pass exec only,
// queries pass exec and query, complete passes exec and complete, allocation passes exec, alloc and,
// behind a tail, alloc_tail; free passes exec, free, free_next and/or free_prev; dispatch passes exec and walk
// one item is in flight at a time; the next is taken in the cycle after the result is loaded
// after reset the pool is ready in the next cycle: written flags give the reset contents
`default_nettype none
module request_slot_pool_dispatcher (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire rspd_pkg::rspd_req_t               in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output rspd_pkg::rspd_rsp_t                    out_data,
  input  wire logic                              cfg_write,
  input  wire logic [rspd_pkg::CFG_IW-1:0]       cfg_index,
  input  wire logic [rspd_pkg::LEN_W-1:0]        cfg_data
);
  import rspd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_EXEC       = 11'b00000000010,
    S_ALLOC      = 11'b00000000100,
    S_ALLOC_TAIL = 11'b00000001000,
    S_FREE       = 11'b00000010000,
    S_FREE_NEXT  = 11'b00000100000,
    S_FREE_PREV  = 11'b00001000000,
    S_QUERY      = 11'b00010000000,
    S_WALK       = 11'b00100000000,
    S_COMPLETE   = 11'b01000000000,
    S_OUT        = 11'b10000000000
  } fsm_t;

  localparam logic [16:0] SIZE_CAP = 17'(SIZE_MAX_BYTES);

  fsm_t               state;
  rspd_req_t          req;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  nx;
  logic [SLOT_W-1:0]  pv;
  logic [COUNT_W-1:0] walk_n;
  logic [SLOT_W-1:0]  vacant_head;
  logic [SLOT_W-1:0]  queue_head;
  logic [SLOT_W-1:0]  queue_tail;
  logic [SLOT_W-1:0]  current_slot;
  logic [COUNT_W-1:0] vacant_count;
  logic [LEN_W-1:0]   key_limit;
  logic [LEN_W-1:0]   data_limit;
  logic [2:0]         res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [2:0]         res_state;
  logic [1:0]         res_cmd;
  logic [LEN_W-1:0]   res_size;

  rspd_mem_cmd_t mem_cmd;
  rspd_info_t    info_rd;
  rspd_link_t    link_rd;
  rspd_info_t    done_info;
  logic [LEN_W-1:0] read_cap;
  logic          too_long;
  logic          finished;
  logic          out_load;

  function automatic logic valid_slot(logic [SLOT_W-1:0] s);
    return 32'(s) < SLOTS;
  endfunction

  function automatic logic [SLOT_AW-1:0] addr(logic [SLOT_W-1:0] s);
    return s[SLOT_AW-1:0];
  endfunction

  rspd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mem_cmd),
    .info_rd (info_rd),
    .link_rd (link_rd)
  );

  assign too_long = (req.key_length >= key_limit) ||
                    (req.op == OP_ALLOC_WRITE && req.data_length >= data_limit);
  assign finished = (info_rd.state == SLOT_DONE) || (info_rd.state == SLOT_ERROR);
  assign read_cap = ({4'b0, data_limit} > SIZE_CAP) ? SIZE_CAP[LEN_W-1:0] : data_limit;

  always_comb begin
    done_info = info_rd;
    if (req.transfer_failed) begin
      done_info.state = SLOT_ERROR;
    end else begin
      done_info.state = SLOT_DONE;
      if (info_rd.command == CMD_READ) begin
        done_info.size = (req.transfer_size > read_cap) ? read_cap : req.transfer_size;
      end
    end
  end

  // memory access per sequencer step
  always_comb begin
    mem_cmd = '0;
    case (state)
      S_EXEC: begin
        case (req.op)
          OP_ALLOC_READ, OP_ALLOC_WRITE: begin
            mem_cmd.link_raddr = addr(vacant_head);
          end
          OP_FREE: begin
            mem_cmd.info_raddr = addr(req.slot_index);
            mem_cmd.link_raddr = addr(req.slot_index);
          end
          OP_QUERY_STATE, OP_QUERY_SIZE: begin
            mem_cmd.info_raddr = addr(req.slot_index);
          end
          OP_DISPATCH: begin
            mem_cmd.info_raddr = addr(queue_head);
            mem_cmd.link_raddr = addr(queue_head);
          end
          OP_COMPLETE: begin
            mem_cmd.info_raddr = addr(current_slot);
          end
          default: begin
            mem_cmd = '0;
          end
        endcase
      end
      S_ALLOC: begin
        mem_cmd.info_we    = 1'b1;
        mem_cmd.info_waddr = addr(slot);
        mem_cmd.info_wdata.state   = SLOT_WAITING;
        mem_cmd.info_wdata.command = (req.op == OP_ALLOC_READ) ? CMD_READ : CMD_WRITE;
        mem_cmd.info_wdata.size    = (req.op == OP_ALLOC_READ) ? '0 : req.data_length;
        mem_cmd.link_we    = 1'b1;
        mem_cmd.link_waddr = addr(slot);
        mem_cmd.link_wdata = '{nxt: NIL, prv: queue_tail};
        mem_cmd.link_raddr = addr(queue_tail);
      end
      S_ALLOC_TAIL: begin
        mem_cmd.link_we    = 1'b1;
        mem_cmd.link_waddr = addr(queue_tail);
        mem_cmd.link_wdata = '{nxt: slot, prv: link_rd.prv};
      end
      S_FREE: begin
        if (finished) begin
          mem_cmd.info_we    = 1'b1;
          mem_cmd.info_waddr = addr(slot);
          mem_cmd.info_wdata = '{state: SLOT_VACANT, command: info_rd.command,
                                 size: info_rd.size};
          mem_cmd.link_we    = 1'b1;
          mem_cmd.link_waddr = addr(slot);
          mem_cmd.link_wdata = '{nxt: vacant_head, prv: NIL};
          mem_cmd.link_raddr = valid_slot(link_rd.nxt) ? addr(link_rd.nxt) : addr(link_rd.prv);
        end
      end
      S_FREE_NEXT: begin
        mem_cmd.link_we    = 1'b1;
        mem_cmd.link_waddr = addr(nx);
        mem_cmd.link_wdata = '{nxt: link_rd.nxt, prv: pv};
        mem_cmd.link_raddr = addr(pv);
      end
      S_FREE_PREV: begin
        mem_cmd.link_we    = 1'b1;
        mem_cmd.link_waddr = addr(pv);
        mem_cmd.link_wdata = '{nxt: nx, prv: link_rd.prv};
      end
      S_WALK: begin
        if (info_rd.state == SLOT_WAITING) begin
          mem_cmd.info_we    = 1'b1;
          mem_cmd.info_waddr = addr(slot);
          mem_cmd.info_wdata = '{state: SLOT_PROGRESS, command: info_rd.command,
                                 size: info_rd.size};
        end else begin
          mem_cmd.info_raddr = addr(link_rd.nxt);
          mem_cmd.link_raddr = addr(link_rd.nxt);
        end
      end
      S_COMPLETE: begin
        mem_cmd.info_we    = 1'b1;
        mem_cmd.info_waddr = addr(slot);
        mem_cmd.info_wdata = done_info;
      end
      default: begin
        mem_cmd = '0;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vacant_head  <= '0;
      queue_head   <= NIL;
      queue_tail   <= NIL;
      current_slot <= NIL;
      vacant_count <= COUNT_W'(SLOTS);
      key_limit    <= LEN_W'(256);
      data_limit   <= LEN_W'(4096);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_KEY_LIMIT:  key_limit  <= cfg_data;
          CFG_DATA_LIMIT: data_limit <= cfg_data;
          default:        key_limit  <= key_limit;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          case (req.op)
            OP_ALLOC_READ, OP_ALLOC_WRITE: begin
              if (!too_long && vacant_count != '0 && valid_slot(vacant_head)) begin
                state <= S_ALLOC;
              end
            end
            OP_FREE, OP_QUERY_STATE, OP_QUERY_SIZE: begin
              if (valid_slot(req.slot_index)) begin
                state <= (req.op == OP_FREE) ? S_FREE : S_QUERY;
              end
            end
            OP_DISPATCH: begin
              if (!valid_slot(current_slot) && valid_slot(queue_head)) begin
                state <= S_WALK;
              end
            end
            OP_COMPLETE: begin
              if (valid_slot(current_slot)) begin
                state <= S_COMPLETE;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_ALLOC: begin
          vacant_head  <= link_rd.nxt;
          vacant_count <= vacant_count - COUNT_W'(1);
          if (valid_slot(queue_tail)) begin
            state <= S_ALLOC_TAIL;
          end else begin
            queue_head <= slot;
            queue_tail <= slot;
            state      <= S_OUT;
          end
        end
        S_ALLOC_TAIL: begin
          queue_tail <= slot;
          state      <= S_OUT;
        end
        S_FREE: begin
          state <= S_OUT;
          if (finished) begin
            if (32'(vacant_count) < SLOTS) begin
              vacant_count <= vacant_count + COUNT_W'(1);
            end
            if (queue_head == slot) begin
              queue_head <= link_rd.nxt;
            end
            if (queue_tail == slot) begin
              queue_tail <= link_rd.prv;
            end
            vacant_head <= slot;
            if (valid_slot(link_rd.nxt)) begin
              state <= S_FREE_NEXT;
            end else if (valid_slot(link_rd.prv)) begin
              state <= S_FREE_PREV;
            end
          end
        end
        S_FREE_NEXT: begin
          state <= valid_slot(pv) ? S_FREE_PREV : S_OUT;
        end
        S_FREE_PREV: begin
          state <= S_OUT;
        end
        S_QUERY: begin
          state <= S_OUT;
        end
        S_WALK: begin
          if (info_rd.state == SLOT_WAITING) begin
            current_slot <= slot;
            state        <= S_OUT;
          end else if (!(32'(walk_n) < SLOTS && valid_slot(link_rd.nxt))) begin
            state <= S_OUT;
          end
        end
        S_COMPLETE: begin
          current_slot <= NIL;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers and result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req <= in_data;
      end
      S_EXEC: begin
        res_status <= STS_OK;
        res_slot   <= '0;
        res_state  <= SLOT_VACANT;
        res_cmd    <= CMD_NONE;
        res_size   <= '0;
        walk_n     <= COUNT_W'(1);
        case (req.op)
          OP_ALLOC_READ, OP_ALLOC_WRITE: begin
            slot <= vacant_head;
            if (too_long) begin
              res_status <= STS_TOO_LONG;
            end else if (vacant_count == '0 || !valid_slot(vacant_head)) begin
              res_status <= STS_OUT_OF_SLOTS;
            end
          end
          OP_FREE, OP_QUERY_STATE, OP_QUERY_SIZE: begin
            slot <= req.slot_index;
            if (!valid_slot(req.slot_index)) begin
              res_status <= STS_INVALID_SLOT;
            end
          end
          OP_DISPATCH: begin
            slot <= queue_head;
            if (valid_slot(current_slot) || !valid_slot(queue_head)) begin
              res_status <= STS_NOTHING;
            end
          end
          OP_COMPLETE: begin
            slot <= current_slot;
            if (!valid_slot(current_slot)) begin
              res_status <= STS_NO_CURRENT;
            end
          end
          default: begin
            slot <= '0;
          end
        endcase
      end
      S_ALLOC: begin
        res_slot <= slot;
      end
      S_FREE: begin
        nx <= link_rd.nxt;
        pv <= link_rd.prv;
        if (!finished) begin
          res_status <= STS_INVALID_SLOT;
        end
      end
      S_QUERY: begin
        if (req.op == OP_QUERY_STATE) begin
          res_slot  <= slot;
          res_state <= info_rd.state;
        end else if (info_rd.state != SLOT_DONE) begin
          res_status <= STS_INVALID_SLOT;
        end else begin
          res_slot  <= slot;
          res_state <= info_rd.state;
          res_size  <= info_rd.size;
        end
      end
      S_WALK: begin
        if (info_rd.state == SLOT_WAITING) begin
          res_slot  <= slot;
          res_state <= SLOT_PROGRESS;
          res_cmd   <= info_rd.command;
          res_size  <= info_rd.size;
        end else if (32'(walk_n) < SLOTS && valid_slot(link_rd.nxt)) begin
          slot   <= link_rd.nxt;
          walk_n <= walk_n + COUNT_W'(1);
        end else begin
          res_status <= STS_NOTHING;
        end
      end
      S_COMPLETE: begin
        res_slot  <= slot;
        res_state <= done_info.state;
        res_cmd   <= done_info.command;
        res_size  <= done_info.size;
      end
      default: begin
        slot <= slot;
      end
    endcase
    if (out_load) begin
      out_data <= '{status: res_status, slot_out: res_slot[5:0], slot_state: res_state,
                    command: res_cmd, slot_size: res_size, free_count: vacant_count};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(vacant_count) <= SLOTS)
    else $error("free count above pool size");

  a_current_ok: assert property (@(posedge clk) disable iff (rst)
    current_slot == NIL || valid_slot(current_slot))
    else $error("current slot out of range");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> 32'(walk_n) <= SLOTS)
    else $error("dispatch walk past pool size");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");

endmodule
`default_nettype wire

// ===== tb/request_slot_pool_dispatcher_checker.sv =====
// checker of the request slot pool dispatcher: pool model, expected results and comparison
`default_nettype none
module request_slot_pool_dispatcher_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire rspd_pkg::rspd_req_t           in_data,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire rspd_pkg::rspd_rsp_t           out_data,
  input  wire logic                          cfg_write,
  input  wire logic [rspd_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [rspd_pkg::LEN_W-1:0]    cfg_data,
  output int                                 errors,
  output int                                 pending
);
  import rspd_pkg::*;

  logic [2:0]        st [SLOTS];
  logic [1:0]        cm [SLOTS];
  logic [LEN_W-1:0]  sz [SLOTS];
  logic [SLOT_W-1:0] nx [SLOTS];
  logic [SLOT_W-1:0] pv [SLOTS];
  logic [SLOT_W-1:0] vhead, ahead, atail, cur;
  int                vcount;
  logic [LEN_W-1:0]  key_lim, data_lim;
  rspd_rsp_t         expected_words[$];

  function automatic bit ok_slot(logic [SLOT_W-1:0] s);
    return 32'(s) < SLOTS;
  endfunction

  task automatic pool_reset();
    for (int i = 0; i < SLOTS; i++) begin
      st[i] = SLOT_VACANT;
      cm[i] = CMD_NONE;
      sz[i] = '0;
      nx[i] = (i + 1 < SLOTS) ? SLOT_W'(i + 1) : NIL;
      pv[i] = (i > 0) ? SLOT_W'(i - 1) : NIL;
    end
    vhead = '0;
    ahead = NIL;
    atail = NIL;
    cur = NIL;
    vcount = SLOTS;
    key_lim = 13'd256;
    data_lim = 13'd4096;
  endtask

  function automatic rspd_rsp_t pool_step(rspd_req_t r);
    rspd_rsp_t o;
    logic [SLOT_W-1:0] s, n2, p2;
    logic [LEN_W-1:0] cap;
    o = '0;
    case (r.op)
      OP_ALLOC_READ, OP_ALLOC_WRITE: begin
        if (r.key_length >= key_lim || (r.op == OP_ALLOC_WRITE && r.data_length >= data_lim))
          o.status = STS_TOO_LONG;
        else if (vcount == 0 || !ok_slot(vhead))
          o.status = STS_OUT_OF_SLOTS;
        else begin
          s = vhead;
          vcount--;
          vhead = nx[s];
          if (ok_slot(vhead)) pv[vhead] = NIL;
          pv[s] = atail;
          nx[s] = NIL;
          if (ok_slot(atail)) nx[atail] = s;
          else ahead = s;
          atail = s;
          st[s] = SLOT_WAITING;
          cm[s] = (r.op == OP_ALLOC_READ) ? CMD_READ : CMD_WRITE;
          sz[s] = (r.op == OP_ALLOC_READ) ? '0 : r.data_length;
          o.slot_out = s[5:0];
        end
      end
      OP_FREE: begin
        s = r.slot_index;
        if (!ok_slot(s) || (st[s] != SLOT_DONE && st[s] != SLOT_ERROR))
          o.status = STS_INVALID_SLOT;
        else begin
          n2 = nx[s];
          p2 = pv[s];
          st[s] = SLOT_VACANT;
          if (vcount < SLOTS) vcount++;
          if (ahead == s) ahead = n2;
          if (atail == s) atail = p2;
          if (ok_slot(n2)) pv[n2] = p2;
          if (ok_slot(p2)) nx[p2] = n2;
          nx[s] = vhead;
          pv[s] = NIL;
          vhead = s;
        end
      end
      OP_QUERY_STATE: begin
        s = r.slot_index;
        if (!ok_slot(s)) o.status = STS_INVALID_SLOT;
        else begin
          o.slot_out = s[5:0];
          o.slot_state = st[s];
        end
      end
      OP_QUERY_SIZE: begin
        s = r.slot_index;
        if (!ok_slot(s) || st[s] != SLOT_DONE) o.status = STS_INVALID_SLOT;
        else begin
          o.slot_out = s[5:0];
          o.slot_state = st[s];
          o.slot_size = sz[s];
        end
      end
      OP_DISPATCH: begin
        o.status = STS_NOTHING;
        if (!ok_slot(cur)) begin
          s = ahead;
          for (int k = 0; k < SLOTS && ok_slot(s); k++) begin
            if (st[s] == SLOT_WAITING) begin
              st[s] = SLOT_PROGRESS;
              cur = s;
              o.status = STS_OK;
              o.slot_out = s[5:0];
              o.slot_state = SLOT_PROGRESS;
              o.command = cm[s];
              o.slot_size = sz[s];
              break;
            end
            s = nx[s];
          end
        end
      end
      OP_COMPLETE: begin
        s = cur;
        if (!ok_slot(s)) o.status = STS_NO_CURRENT;
        else begin
          if (r.transfer_failed) st[s] = SLOT_ERROR;
          else begin
            st[s] = SLOT_DONE;
            if (cm[s] == CMD_READ) begin
              cap = (data_lim > SIZE_MAX_BYTES) ? LEN_W'(SIZE_MAX_BYTES) : data_lim;
              sz[s] = (r.transfer_size > cap) ? cap : r.transfer_size;
            end
          end
          cur = NIL;
          o.slot_out = s[5:0];
          o.slot_state = st[s];
          o.command = cm[s];
          o.slot_size = sz[s];
        end
      end
      default: ;
    endcase
    o.free_count = COUNT_W'(vcount);
    return o;
  endfunction

  always @(posedge clk) begin
    rspd_rsp_t e;
    if (rst) begin
      pool_reset();
      expected_words.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_KEY_LIMIT) key_lim = cfg_data;
        else if (cfg_index == CFG_DATA_LIMIT) data_lim = cfg_data;
      end
      if (in_valid && !in_stall) expected_words.push_back(pool_step(in_data));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data) begin
            if (e.status !== out_data.status)
              $error("status exp %0d got %0d", e.status, out_data.status);
            if (e.slot_out !== out_data.slot_out)
              $error("slot_out exp %0d got %0d", e.slot_out, out_data.slot_out);
            if (e.slot_state !== out_data.slot_state)
              $error("slot_state exp %0d got %0d", e.slot_state, out_data.slot_state);
            if (e.command !== out_data.command)
              $error("command exp %0d got %0d", e.command, out_data.command);
            if (e.slot_size !== out_data.slot_size)
              $error("slot_size exp %0d got %0d", e.slot_size, out_data.slot_size);
            if (e.free_count !== out_data.free_count)
              $error("free_count exp %0d got %0d", e.free_count, out_data.free_count);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_words.size();

endmodule
`default_nettype wire

// ===== tb/request_slot_pool_dispatcher_tb.sv =====
// testbench top of the request slot pool dispatcher: stimulus, clock, reset and verdict
`default_nettype none
module request_slot_pool_dispatcher_tb;
  import rspd_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rspd_req_t         in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rspd_rsp_t         out_data;
  logic              cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_KEY_LIMIT;
  logic [LEN_W-1:0]  cfg_data = '0;
  int                errors;
  int                pending;
  int                cycles = 0;
  int                burst_left = 0;
  int                stall_mode = 0;

  localparam int LIMIT = 3000000;

  request_slot_pool_dispatcher dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_write, .cfg_index, .cfg_data
  );

  request_slot_pool_dispatcher_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light, heavy
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_word(rspd_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_op(logic [2:0] op, logic [6:0] idx, logic [LEN_W-1:0] kl,
                         logic [LEN_W-1:0] dl, logic fl, logic [LEN_W-1:0] ts);
    rspd_req_t r;
    r.op = op;
    r.slot_index = idx;
    r.key_length = kl;
    r.data_length = dl;
    r.transfer_failed = fl;
    r.transfer_size = ts;
    send_word(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (SLOTS + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [LEN_W-1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 3))
      0: return LEN_W'($urandom_range(0, 4096));
      1: return LEN_W'($urandom_range(0, 8191));
      default: return LEN_W'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic random_phase(int count);
    rspd_req_t r;
    for (int i = 0; i < count; i++) begin
      r.key_length = rand_len();
      r.data_length = rand_len();
      r.transfer_failed = $urandom_range(0, 3) == 0;
      r.transfer_size = rand_len();
      r.slot_index = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, SLOTS - 1));
      case ($urandom_range(0, 19))
        0, 1, 2:    r.op = OP_ALLOC_READ;
        3, 4, 5:    r.op = OP_ALLOC_WRITE;
        6, 7, 8:    r.op = OP_FREE;
        9, 10:      r.op = OP_QUERY_STATE;
        11, 12, 13: r.op = OP_DISPATCH;
        14, 15, 16: r.op = OP_COMPLETE;
        17, 18:     r.op = OP_QUERY_SIZE;
        default:    r.op = 3'($urandom_range(0, 7));
      endcase
      send_word(r);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty pool corners, length limits, dispatch, complete, free and filling the pool past its size
    send_op(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_op(OP_COMPLETE, 0, 0, 0, 0, 0);
    send_op(OP_FREE, 0, 0, 0, 0, 0);
    send_op(OP_FREE, 7'd127, 0, 0, 0, 0);
    send_op(OP_QUERY_STATE, 7'd127, 0, 0, 0, 0);
    send_op(OP_QUERY_SIZE, 7'd64, 0, 0, 0, 0);
    send_op(OP_ALLOC_READ, 0, 13'd256, 0, 0, 0);
    send_op(OP_ALLOC_WRITE, 0, 13'd255, 13'd4096, 0, 0);
    send_op(OP_ALLOC_WRITE, 0, 13'd255, 13'd4095, 0, 0);
    send_op(OP_ALLOC_READ, 0, 0, 13'h1fff, 0, 0);
    send_op(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_op(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_op(OP_COMPLETE, 0, 0, 0, 0, 13'h1fff);
    send_op(OP_QUERY_SIZE, 0, 0, 0, 0, 0);
    send_op(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_op(OP_COMPLETE, 0, 0, 0, 1, 13'd5);
    send_op(OP_QUERY_STATE, 1, 0, 0, 0, 0);
    send_op(OP_FREE, 1, 0, 0, 0, 0);
    send_op(OP_FREE, 0, 0, 0, 0, 0);
    send_op(3'd7, 7'h7f, 13'h1fff, 13'h1fff, 1, 13'h1fff);
    for (int i = 0; i < SLOTS + 1; i++) send_op(OP_ALLOC_WRITE, 0, 0, 13'(i), 0, 0);
    drain();
    random_phase(300);
    drain();
    write_reg(CFG_KEY_LIMIT, 13'd1);
    write_reg(CFG_DATA_LIMIT, 13'd1);
    random_phase(150);
    drain();
    write_reg(CFG_KEY_LIMIT, 13'd4096);
    write_reg(CFG_DATA_LIMIT, 13'd4096);
    random_phase(300);
    drain();
    write_reg(CFG_KEY_LIMIT, 13'h1fff);
    write_reg(CFG_DATA_LIMIT, 13'd100);
    random_phase(200);
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
